### design/crc8pcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8pcf_pkg
// Shared types, constants and the CRC-8 byte update of the payload framer.
// ----------------------------------------------------------------------------
package crc8pcf_pkg;

  localparam int FRAME_BYTES_DEF = 8;
  localparam int ID_W            = 11;
  localparam int DATA_W          = 64;
  localparam int LEN_W           = 16;

  localparam logic [LEN_W-1:0]  PAYLOAD_RST = 16'd6000;
  localparam logic [ID_W-1:0]   IDENT_RST   = 11'h321;
  localparam logic [7:0]        CRC_POLY    = 8'h07;
  localparam logic [7:0]        PAD_BYTE    = 8'hFF;
  localparam logic [DATA_W-1:0] ONES64      = {DATA_W{1'b1}};

  // configuration register indexes
  localparam logic CFG_PAYLOAD = 1'b0;
  localparam logic CFG_IDENT   = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   identifier;
    logic [DATA_W-1:0] frame_data;
    logic              is_header;
    logic              block_end;
    logic              run_last;
  } result_t;

  typedef struct packed {
    logic v0;
    logic v1;
  } push_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### design/crc8pcf_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8pcf_framer
// Block state, CRC update and frame assembly; yields up to two frames per accepted byte.
// ----------------------------------------------------------------------------
module crc8pcf_framer #(
  parameter int FRAME_BYTES = crc8pcf_pkg::FRAME_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [7:0]                       data_byte_i,
  input  logic [crc8pcf_pkg::LEN_W-1:0]    payload_bytes_i,
  input  logic [crc8pcf_pkg::ID_W-1:0]     frame_identifier_i,
  output crc8pcf_pkg::push_t               push_o,
  output crc8pcf_pkg::result_t             res0_o,
  output crc8pcf_pkg::result_t             res1_o
);

  localparam int BUF_W  = (FRAME_BYTES - 1) * 8;
  localparam int FILL_W = $clog2(FRAME_BYTES);
  localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(FRAME_BYTES - 1);

  logic [7:0]                    crc_q, crc_d;
  logic [crc8pcf_pkg::LEN_W-1:0] taken_q, taken_d;
  logic [BUF_W-1:0]              buf_q, buf_d;
  logic [FILL_W-1:0]             fill_q, fill_d;

  logic [crc8pcf_pkg::DATA_W-1:0] frm_cur, frame1, base_end, frame_end, frame_hdr;
  logic [FILL_W-1:0]              fill_e;
  logic [crc8pcf_pkg::LEN_W-1:0]  total;
  logic [crc8pcf_pkg::LEN_W:0]    count;
  logic [7:0]                     crc_new;
  logic                           hdr, full1, is_end;
  crc8pcf_pkg::result_t           r_hdr, r_full, r_end;

  always_comb begin
    frm_cur = {{(crc8pcf_pkg::DATA_W - BUF_W){1'b1}}, buf_q};
    full1   = (fill_q == LAST_FILL);
    crc_new = crc8pcf_pkg::crc8_update(crc_q, data_byte_i);
    for (int i = 0; i < 8; i++) begin
      frame1[i*8 +: 8] = (i == int'(fill_q)) ? data_byte_i : frm_cur[i*8 +: 8];
    end
    base_end = full1 ? crc8pcf_pkg::ONES64 : frame1;
    fill_e   = full1 ? '0 : fill_q + 1'b1;
    for (int i = 0; i < 8; i++) begin
      frame_end[i*8 +: 8] = (i == int'(fill_e)) ? crc_new : base_end[i*8 +: 8];
    end
    hdr       = (taken_q == '0);
    total     = payload_bytes_i + 16'd1;
    frame_hdr = {crc8pcf_pkg::ONES64[crc8pcf_pkg::DATA_W-1:16], total[7:0], total[15:8]};
    count     = {1'b0, taken_q} + 17'd1;
    is_end    = (count >= {1'b0, payload_bytes_i});

    r_hdr  = '{identifier: frame_identifier_i, frame_data: frame_hdr,
               is_header: 1'b1, block_end: 1'b0, run_last: 1'b0};
    r_full = '{identifier: frame_identifier_i, frame_data: frame1,
               is_header: 1'b0, block_end: 1'b0, run_last: 1'b0};
    r_end  = '{identifier: frame_identifier_i, frame_data: frame_end,
               is_header: 1'b0, block_end: 1'b1, run_last: 1'b0};

    // compact the frames in order: header, full data frame, closing frame
    res0_o = hdr ? r_hdr : (full1 ? r_full : r_end);
    res1_o = hdr ? (full1 ? r_full : r_end) : r_end;
    push_o.v0 = accept_i && (hdr || full1 || is_end);
    push_o.v1 = accept_i && ((hdr && (full1 || is_end)) || (full1 && is_end));
    res0_o.run_last = !push_o.v1;
    res1_o.run_last = 1'b1;

    if (is_end) begin
      crc_d   = '0;
      taken_d = '0;
      buf_d   = '1;
      fill_d  = '0;
    end else begin
      crc_d   = crc_new;
      taken_d = count[crc8pcf_pkg::LEN_W-1:0];
      buf_d   = full1 ? '1 : frame1[BUF_W-1:0];
      fill_d  = fill_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      taken_q <= '0;
      buf_q   <= '1;
      fill_q  <= '0;
    end else if (accept_i) begin
      crc_q   <= crc_d;
      taken_q <= taken_d;
      buf_q   <= buf_d;
      fill_q  <= fill_d;
    end
  end

endmodule

### design/crc8pcf_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8pcf_out_fifo
// Four-entry result queue: two writes, one read per cycle.
// ----------------------------------------------------------------------------
module crc8pcf_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crc8pcf_pkg::push_t   push_i,
  input  crc8pcf_pkg::result_t res0_i,
  input  crc8pcf_pkg::result_t res1_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output crc8pcf_pkg::result_t res_o
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  crc8pcf_pkg::result_t mem_q [DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] n_push;
  logic             pop;

  always_comb begin
    pop     = valid_o && ready_i;
    n_push  = CNT_W'(push_i.v0) + CNT_W'(push_i.v1);
    wp_d    = wp_q + PTR_W'(n_push);
    rp_d    = rp_q + PTR_W'(pop);
    cnt_d   = cnt_q + n_push - CNT_W'(pop);
    valid_o = (cnt_q != '0);
    room_o  = (cnt_q <= CNT_W'(DEPTH - 2));
    res_o   = mem_q[rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wp_q] <= res0_i;
    end
    if (push_i.v1) begin
      mem_q[wp_q + 1'b1] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### design/crc8_payload_can_framer_unit.sv
`timescale 1ns / 1ps
// A frame caused by an accepted byte is registered in the result queue and waits
// there behind earlier frames. Throughput: one byte per cycle while each byte makes
// at most one frame and the master is ready; a byte that makes two frames needs
// two reads from the single read port of the four-entry result queue.
// Reset: asynchronous, clears block state and queue; registers take 6000 and 0x321.
// ----------------------------------------------------------------------------
// crc8_payload_can_framer_unit
// Cuts payload blocks into CAN data frames with length header and CRC-8 trailer.
// ----------------------------------------------------------------------------
module crc8_payload_can_framer_unit #(
  parameter int FRAME_BYTES = crc8pcf_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [10:0] identifier, [74:11] frame_data, zero fill
  output logic [1:0]  m_axis_tuser,   // [0] is_header, [1] block_end
  output logic        m_axis_tlast,   // run_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [crc8pcf_pkg::LEN_W-1:0] payload_q;
  logic [crc8pcf_pkg::ID_W-1:0]  ident_q;
  logic                          accept;
  crc8pcf_pkg::push_t            push;
  crc8pcf_pkg::result_t          res0, res1, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q <= crc8pcf_pkg::PAYLOAD_RST;
      ident_q   <= crc8pcf_pkg::IDENT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        crc8pcf_pkg::CFG_PAYLOAD: payload_q <= cfg_data_i;
        crc8pcf_pkg::CFG_IDENT:   ident_q   <= cfg_data_i[crc8pcf_pkg::ID_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  crc8pcf_framer #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_framer (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .data_byte_i       (s_axis_tdata),
    .payload_bytes_i   (payload_q),
    .frame_identifier_i(ident_q),
    .push_o            (push),
    .res0_o            (res0),
    .res1_o            (res1)
  );

  crc8pcf_out_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res0_i (res0),
    .res1_i (res1),
    .room_o (s_axis_tready),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .res_o  (res_out)
  );

  assign m_axis_tdata = {5'b0, res_out.frame_data, res_out.identifier};
  assign m_axis_tuser = {res_out.block_end, res_out.is_header};
  assign m_axis_tlast = res_out.run_last;

endmodule

### design/crc8pcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8pcf_checker
// Port-level checks of the framer, bound to the top level.
// ----------------------------------------------------------------------------
module crc8pcf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no frame pending");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("closing frame not last or marked header");

  a_hdr_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[74:27] == {48{1'b1}})
    else $error("header frame padding wrong");

endmodule

bind crc8_payload_can_framer_unit crc8pcf_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
